[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous reset disable.
`define ALE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold whenever a word is shown on the result channel.
`define ALE_ASSERT_ON_RSP(label, cond, msg) \
	`ALE_ASSERT(label, (rsp_valid |-> (cond)), msg)

`endif

[rtl/core/ale_pkg.sv]
package ale_pkg;

	localparam int CAPACITY  = 128;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int COUNT_W   = $clog2(CAPACITY + 1);
	localparam int DATA_W    = 32;

	// Command opcodes.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_DEL_VAL   = 3'd6,
		OP_SEARCH    = 3'd7
	} opcode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [7:0]         position;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               hit;
		logic [6:0]         hit_index;
		logic [7:0]         entry_count;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
		logic               empty_flag;
		logic               full_flag;
	} rsp_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_UP_RD,
		S_UP_WR,
		S_INS_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DN_RD,
		S_DN_WR,
		S_SCAN_INIT,
		S_SCAN_RD,
		S_SCAN_ACC,
		S_FIN
	} state_t;

	// Index register updates.
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_USED,
		IDX_ZERO,
		IDX_DEL,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	// Read address selection relative to the index register.
	typedef enum logic [1:0] {
		RD_IDX_M1,
		RD_IDX,
		RD_IDX_P1
	} rd_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic      load;
		idx_op_t   idx_op;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_shift;
		logic      wr_insert;
		logic      used_inc;
		logic      used_dec;
		logic      st_set;
		status_t   st_code;
		logic      hit_set;
		logic      mm_clear;
		logic      mm_acc;
		logic      out_load;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    ins_bad;
		logic    del_bad;
		logic    idx_gt_ins;
		logic    idx_lt_used;
		logic    idx_p1_lt_used;
		logic    match;
		logic    out_free;
	} dp_stat_t;

endpackage

[rtl/core/array_list_engine_core.sv]
// A rejected command goes straight from the check to the result; a search walks the entries,
// and an insert or delete shifts the entries behind its position and then rescans them all.
// One command at a time; each walk step reads a word through the single read port of the
// entry store and then uses it. The result register lets a new command enter early.
// Reset: arst_n clears the count, status and min/max at once; the store is not cleared.
module array_list_engine_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ale_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ale_pkg::rsp_t  rsp
);

	import ale_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Sequencer.
	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Store, counters and result register.
	ale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[rtl/core/ale_ram.sv]
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ale_ctrl.sv]
module ale_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ale_pkg::dp_stat_t  stat,
	output ale_pkg::ctl_cmd_t  ctl
);

	import ale_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.idx_op  = IDX_HOLD;
		ctl.rd_sel  = RD_IDX;
		ctl.st_code = ST_OK;
		cmd_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (stat.op)
					OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
						if (stat.full) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_FULL;
							state_d     = S_FIN;
						end else if (stat.ins_bad) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_BADPOS;
							state_d     = S_FIN;
						end else begin
							ctl.idx_op = IDX_USED;
							state_d    = S_UP_RD;
						end
					end
					OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
						if (stat.empty) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_EMPTY;
							state_d     = S_FIN;
						end else if (stat.del_bad) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_BADPOS;
							state_d     = S_FIN;
						end else begin
							ctl.idx_op = IDX_DEL;
							state_d    = S_DN_RD;
						end
					end
					OP_DEL_VAL: begin
						if (stat.empty) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_EMPTY;
							state_d     = S_FIN;
						end else begin
							ctl.idx_op = IDX_ZERO;
							state_d    = S_SRCH_RD;
						end
					end
					default: begin
						ctl.idx_op = IDX_ZERO;
						state_d    = S_SRCH_RD;
					end
				endcase
			end
			// Open a gap: move entry idx-1 up to idx until the insert point.
			S_UP_RD: begin
				if (stat.idx_gt_ins) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX_M1;
					state_d    = S_UP_WR;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_UP_WR: begin
				ctl.wr_shift = 1'b1;
				ctl.idx_op   = IDX_DEC;
				state_d      = S_UP_RD;
			end
			S_INS_WR: begin
				ctl.wr_insert = 1'b1;
				ctl.used_inc  = 1'b1;
				state_d       = S_SCAN_INIT;
			end
			// Linear search for the first matching word.
			S_SRCH_RD: begin
				if (stat.idx_lt_used) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX;
					state_d    = S_SRCH_CMP;
				end else begin
					ctl.st_set  = 1'b1;
					ctl.st_code = ST_NOTFOUND;
					state_d     = S_FIN;
				end
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					ctl.hit_set = 1'b1;
					if (stat.op == OP_SEARCH) begin
						state_d = S_FIN;
					end else begin
						state_d = S_DN_RD;
					end
				end else begin
					ctl.idx_op = IDX_INC;
					state_d    = S_SRCH_RD;
				end
			end
			// Close the gap: move entry idx+1 down to idx.
			S_DN_RD: begin
				if (stat.idx_p1_lt_used) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX_P1;
					state_d    = S_DN_WR;
				end else begin
					ctl.used_dec = 1'b1;
					state_d      = S_SCAN_INIT;
				end
			end
			S_DN_WR: begin
				ctl.wr_shift = 1'b1;
				ctl.idx_op   = IDX_INC;
				state_d      = S_DN_RD;
			end
			// Rescan the contents for minimum and maximum.
			S_SCAN_INIT: begin
				ctl.idx_op   = IDX_ZERO;
				ctl.mm_clear = 1'b1;
				state_d      = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (stat.idx_lt_used) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX;
					state_d    = S_SCAN_ACC;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SCAN_ACC: begin
				ctl.mm_acc = 1'b1;
				ctl.idx_op = IDX_INC;
				state_d    = S_SCAN_RD;
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/ale_dp.sv]
module ale_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ale_pkg::cmd_t      cmd,
	input  ale_pkg::ctl_cmd_t  ctl,
	output ale_pkg::dp_stat_t  stat,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ale_pkg::rsp_t      rsp
);

	import ale_pkg::*;

	logic [2:0]          op_q;
	logic [COUNT_W-1:0]  pos_q;
	logic [DATA_W-1:0]   val_q;
	logic [COUNT_W-1:0]  used_q;
	logic [COUNT_W-1:0]  idx_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	status_t             status_q;
	logic                hit_q;
	logic [ADDR_W-1:0]   hidx_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [COUNT_W-1:0]  ins_pos;
	logic [COUNT_W-1:0]  del_pos;
	logic [COUNT_W-1:0]  idx_m1;
	logic [COUNT_W-1:0]  idx_p1;
	logic [COUNT_W-1:0]  rd_idx;
	logic [DATA_W-1:0]   rdata;
	logic signed [DATA_W-1:0] rword;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [DATA_W-1:0]   wdata;

	// Position the command works on, taken from the opcode.
	always_comb begin
		priority case (op_q)
			OP_INS_FRONT: ins_pos = '0;
			OP_INS_BACK:  ins_pos = used_q;
			default:      ins_pos = pos_q;
		endcase
		priority case (op_q)
			OP_DEL_FRONT: del_pos = '0;
			OP_DEL_BACK:  del_pos = used_q - COUNT_W'(1);
			default:      del_pos = pos_q;
		endcase
	end

	assign idx_m1 = idx_q - COUNT_W'(1);
	assign idx_p1 = idx_q + COUNT_W'(1);
	assign rword  = $signed(rdata);

	always_comb begin
		unique case (ctl.rd_sel)
			RD_IDX_M1: rd_idx = idx_m1;
			RD_IDX_P1: rd_idx = idx_p1;
			default:   rd_idx = idx_q;
		endcase
	end

	// Shifts write the word just read to idx; an insert writes the new word.
	assign we    = ctl.wr_shift | ctl.wr_insert;
	assign waddr = ctl.wr_insert ? ins_pos[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
	assign wdata = ctl.wr_insert ? val_q : rdata;

	ale_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.rd_en),
		.raddr (rd_idx[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// Command latch and index register.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd.opcode;
			pos_q <= cmd.position;
			val_q <= cmd.value;
		end
		unique case (ctl.idx_op)
			IDX_USED: idx_q <= used_q;
			IDX_ZERO: idx_q <= '0;
			IDX_DEL:  idx_q <= del_pos;
			IDX_INC:  idx_q <= idx_p1;
			IDX_DEC:  idx_q <= idx_m1;
			default:  idx_q <= idx_q;
		endcase
	end

	// List size, status and running minimum and maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			status_q <= ST_OK;
			hit_q    <= 1'b0;
			hidx_q   <= '0;
		end else begin
			if (ctl.load) begin
				status_q <= ST_OK;
				hit_q    <= 1'b0;
				hidx_q   <= '0;
			end
			if (ctl.st_set) begin
				status_q <= ctl.st_code;
			end
			if (ctl.hit_set) begin
				hit_q  <= 1'b1;
				hidx_q <= idx_q[ADDR_W-1:0];
			end
			if (ctl.used_inc) begin
				used_q <= used_q + COUNT_W'(1);
			end else if (ctl.used_dec) begin
				used_q <= used_q - COUNT_W'(1);
			end
			if (ctl.mm_clear) begin
				lo_q <= '0;
				hi_q <= '0;
			end else if (ctl.mm_acc) begin
				if (idx_q == '0 || rword < lo_q) begin
					lo_q <= rword;
				end
				if (idx_q == '0 || rword > hi_q) begin
					hi_q <= rword;
				end
			end
		end
	end

	// Output register decouples the result from the next command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.status      <= status_q;
			rsp_q.hit         <= hit_q;
			rsp_q.hit_index   <= hidx_q;
			rsp_q.entry_count <= used_q;
			rsp_q.smallest    <= lo_q;
			rsp_q.largest     <= hi_q;
			rsp_q.empty_flag  <= (used_q == '0);
			rsp_q.full_flag   <= (used_q == COUNT_W'(CAPACITY));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status toward the controller.
	assign stat.op             = opcode_t'(op_q);
	assign stat.full           = (used_q == COUNT_W'(CAPACITY));
	assign stat.empty          = (used_q == '0);
	assign stat.ins_bad        = (op_q == OP_INS_POS) && (pos_q > used_q);
	assign stat.del_bad        = (op_q == OP_DEL_POS) && (pos_q >= used_q);
	assign stat.idx_gt_ins     = (idx_q > ins_pos);
	assign stat.idx_lt_used    = (idx_q < used_q);
	assign stat.idx_p1_lt_used = (idx_p1 < used_q);
	assign stat.match          = (rdata == val_q);
	assign stat.out_free       = !rsp_valid_q || rsp_ready;

endmodule

[rtl/core/ale_checker.sv]
`include "assert_macros.svh"

module ale_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input ale_pkg::cmd_t  cmd,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ale_pkg::rsp_t  rsp
);

	import ale_pkg::*;

	// A stalled command word stays offered with the same payload.
	`ALE_ASSERT(a_cmd_hold, (cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd)), "command word changed while stalled")

	// A stalled result word stays offered.
	`ALE_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid), "result word dropped")

	// Flags agree with the count.
	`ALE_ASSERT_ON_RSP(a_flags, (rsp.empty_flag == (rsp.entry_count == 8'd0)) && (rsp.full_flag == (rsp.entry_count == 8'(CAPACITY))), "flags disagree with count")

	// A rejected command reports no hit.
	`ALE_ASSERT_ON_RSP(a_reject_nohit, (rsp.status == ST_OK || (!rsp.hit && rsp.hit_index == 7'd0)), "hit on rejected command")

	// An empty list reports zero extremes; otherwise minimum does not exceed maximum.
	`ALE_ASSERT_ON_RSP(a_extremes, (rsp.empty_flag ? (rsp.smallest == 0 && rsp.largest == 0) : (rsp.smallest <= rsp.largest)), "bad min/max")

endmodule

bind array_list_engine_core ale_checker u_ale_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
